// ===== sv/shl2_pkg.sv =====
// Shared types, widths and constants of the spherical harmonics irradiance unit.
package shl2_pkg;

	localparam int N_TERMS = 9;
	localparam int IDX_W   = 4;
	localparam int COEF_W  = 64;
	localparam int NRM_W   = 34;
	localparam int QUAD_W  = 36;
	localparam int BASIS_W = 38;
	localparam int OPB_W   = 34;
	localparam int PROD_W  = BASIS_W + OPB_W;
	localparam int OUT_W   = 63;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	localparam logic signed [OPB_W-1:0] K0     = 34'sd1211559817;
	localparam logic signed [OPB_W-1:0] K1     = 34'sd2098485297;
	localparam logic signed [OPB_W-1:0] NEG_K1 = -34'sd2098485297;
	localparam logic signed [OPB_W-1:0] K2     = 34'sd4692484050;
	localparam logic signed [OPB_W-1:0] NEG_K2 = -34'sd4692484050;
	localparam logic signed [OPB_W-1:0] K3     = 34'sd1354578131;
	localparam logic signed [OPB_W-1:0] K4     = 34'sd2346242025;
	localparam logic signed [BASIS_W-1:0] Q_ONE = 38'sd4294967296;

	typedef enum logic [1:0] {PH_LO, PH_HI, PH_SUM, PH_ACC} mac_ph_t;

	typedef struct packed {
		logic    clear;
		logic    run;
		mac_ph_t ph;
	} mac_ctrl_t;

	typedef struct packed {
		logic               we;
		logic [IDX_W-1:0]   idx;
		logic [BASIS_W-1:0] val;
	} basis_wr_t;

	typedef struct packed {
		logic load;
		logic bwe;
		logic shift;
	} cell_ctl_t;

endpackage

// ===== sv/shl2_cell.sv =====
// One cell of the coefficient ring: a coefficient triple and its basis value.
module shl2_cell (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  shl2_pkg::cell_ctl_t                      ctl,
	input  logic signed [shl2_pkg::COEF_W-1:0]       ld_r,
	input  logic signed [shl2_pkg::COEF_W-1:0]       ld_g,
	input  logic signed [shl2_pkg::COEF_W-1:0]       ld_b,
	input  logic signed [shl2_pkg::BASIS_W-1:0]      bval,
	input  logic signed [shl2_pkg::COEF_W-1:0]       nx_r,
	input  logic signed [shl2_pkg::COEF_W-1:0]       nx_g,
	input  logic signed [shl2_pkg::COEF_W-1:0]       nx_b,
	input  logic signed [shl2_pkg::BASIS_W-1:0]      nx_bs,
	output logic signed [shl2_pkg::COEF_W-1:0]       cur_r,
	output logic signed [shl2_pkg::COEF_W-1:0]       cur_g,
	output logic signed [shl2_pkg::COEF_W-1:0]       cur_b,
	output logic signed [shl2_pkg::BASIS_W-1:0]      cur_bs
);

	logic signed [shl2_pkg::COEF_W-1:0]  r_q, g_q, b_q;
	logic signed [shl2_pkg::BASIS_W-1:0] bs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			g_q <= '0;
			b_q <= '0;
		end else if (ctl.load) begin
			r_q <= ld_r;
			g_q <= ld_g;
			b_q <= ld_b;
		end else if (ctl.shift) begin
			r_q <= nx_r;
			g_q <= nx_g;
			b_q <= nx_b;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.bwe) begin
			bs_q <= bval;
		end else if (ctl.shift) begin
			bs_q <= nx_bs;
		end
	end

	assign cur_r  = r_q;
	assign cur_g  = g_q;
	assign cur_b  = b_q;
	assign cur_bs = bs_q;

endmodule

// ===== sv/shl2_basis.sv =====
// Basis sequencer: builds the nine basis values with one shared multiplier.
module shl2_basis (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [shl2_pkg::NRM_W-1:0]    nx,
	input  logic signed [shl2_pkg::NRM_W-1:0]    ny,
	input  logic signed [shl2_pkg::NRM_W-1:0]    nz,
	output shl2_pkg::basis_wr_t                  wr,
	output logic                                 done
);

	typedef enum logic [3:0] {
		S_XY, S_YZ, S_XZ, S_ZZ, S_XX, S_YY,
		S_Y1, S_Y2, S_Y3, S_Y4, S_Y5, S_Y6, S_Y7, S_Y8
	} step_t;

	step_t step_q;
	logic  busy_q;
	logic signed [shl2_pkg::NRM_W-1:0]   x_q, y_q, z_q;
	logic signed [shl2_pkg::QUAD_W-1:0]  xy_q, yz_q, xz_q, zz_q, xx_q, yy_q;
	logic signed [shl2_pkg::BASIS_W-1:0] a_op, t6, d8;
	logic signed [shl2_pkg::OPB_W-1:0]   b_op;
	logic signed [shl2_pkg::PROD_W-1:0]  prod;
	logic [shl2_pkg::IDX_W-1:0]          idx;

	always_comb begin
		t6 = (shl2_pkg::BASIS_W'(zz_q) <<< 1) + shl2_pkg::BASIS_W'(zz_q) - shl2_pkg::Q_ONE;
		d8 = shl2_pkg::BASIS_W'(xx_q) - shl2_pkg::BASIS_W'(yy_q);
		a_op = '0;
		b_op = '0;
		idx  = '0;
		case (step_q)
			S_XY: begin a_op = shl2_pkg::BASIS_W'(x_q);  b_op = y_q; end
			S_YZ: begin a_op = shl2_pkg::BASIS_W'(y_q);  b_op = z_q; end
			S_XZ: begin a_op = shl2_pkg::BASIS_W'(x_q);  b_op = z_q; end
			S_ZZ: begin a_op = shl2_pkg::BASIS_W'(z_q);  b_op = z_q; end
			S_XX: begin a_op = shl2_pkg::BASIS_W'(x_q);  b_op = x_q; end
			S_YY: begin a_op = shl2_pkg::BASIS_W'(y_q);  b_op = y_q; end
			S_Y1: begin a_op = shl2_pkg::BASIS_W'(y_q);  b_op = shl2_pkg::NEG_K1; idx = 4'd1; end
			S_Y2: begin a_op = shl2_pkg::BASIS_W'(z_q);  b_op = shl2_pkg::K1;     idx = 4'd2; end
			S_Y3: begin a_op = shl2_pkg::BASIS_W'(x_q);  b_op = shl2_pkg::NEG_K1; idx = 4'd3; end
			S_Y4: begin a_op = shl2_pkg::BASIS_W'(xy_q); b_op = shl2_pkg::K2;     idx = 4'd4; end
			S_Y5: begin a_op = shl2_pkg::BASIS_W'(yz_q); b_op = shl2_pkg::NEG_K2; idx = 4'd5; end
			S_Y6: begin a_op = t6;                       b_op = shl2_pkg::K3;     idx = 4'd6; end
			S_Y7: begin a_op = shl2_pkg::BASIS_W'(xz_q); b_op = shl2_pkg::NEG_K2; idx = 4'd7; end
			S_Y8: begin a_op = d8;                       b_op = shl2_pkg::K4;     idx = 4'd8; end
			default: begin a_op = '0; b_op = '0; idx = '0; end
		endcase
		prod = a_op * b_op;
		wr.we  = busy_q && (step_q == S_XY || step_q >= S_Y1);
		wr.idx = idx;
		wr.val = (step_q == S_XY) ? shl2_pkg::BASIS_W'(shl2_pkg::K0) : prod[69:32];
	end

	assign done = busy_q && step_q == S_Y8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= S_XY;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= S_XY;
		end else if (busy_q) begin
			if (step_q == S_Y8) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_t'(step_q + 4'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= nx;
			y_q <= ny;
			z_q <= nz;
		end else if (busy_q) begin
			case (step_q)
				S_XY:    xy_q <= prod[67:32];
				S_YZ:    yz_q <= prod[67:32];
				S_XZ:    xz_q <= prod[67:32];
				S_ZZ:    zz_q <= prod[67:32];
				S_XX:    xx_q <= prod[67:32];
				S_YY:    yy_q <= prod[67:32];
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/shl2_mac.sv =====
// Per-channel multiply-accumulate with saturating product and running sum.
module shl2_mac (
	input  logic                                 clk,
	input  shl2_pkg::mac_ctrl_t                  ctrl,
	input  logic signed [shl2_pkg::COEF_W-1:0]   coef,
	input  logic signed [shl2_pkg::BASIS_W-1:0]  basis,
	output logic signed [shl2_pkg::COEF_W-1:0]   acc
);

	logic signed [shl2_pkg::OPB_W-1:0]   b_op;
	logic signed [shl2_pkg::PROD_W-1:0]  prod, hi_q, sum;
	logic signed [39:0]                  lo_q;
	logic signed [shl2_pkg::COEF_W-1:0]  prod_q, sat_prod, acc_q, acc_nx;
	logic signed [shl2_pkg::COEF_W:0]    acc_sum;

	always_comb begin
		if (ctrl.ph == shl2_pkg::PH_LO) begin
			b_op = {2'b00, coef[31:0]};
		end else begin
			b_op = {{2{coef[63]}}, coef[63:32]};
		end
		prod = basis * b_op;
		sum  = hi_q + shl2_pkg::PROD_W'(lo_q);
		if (sum[71:63] != {9{sum[71]}}) begin
			sat_prod = sum[71] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			sat_prod = sum[63:0];
		end
		acc_sum = {acc_q[63], acc_q} + {prod_q[63], prod_q};
		if (acc_sum[64] != acc_sum[63]) begin
			acc_nx = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			acc_nx = acc_sum[63:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.run) begin
			case (ctrl.ph)
				shl2_pkg::PH_LO:  lo_q   <= prod[71:32];
				shl2_pkg::PH_HI:  hi_q   <= prod;
				shl2_pkg::PH_SUM: prod_q <= sat_prod;
				shl2_pkg::PH_ACC: acc_q  <= acc_nx;
				default: ;
			endcase
		end
	end

	assign acc = acc_q;

endmodule

// ===== sv/sh_l2_irradiance_eval_unit.sv =====
// Top level of the nine-term spherical harmonics irradiance evaluator.
// A load beat writes one coefficient triple and returns no result; a load with an index
// above eight is dropped. An evaluate beat first runs the basis sequencer, whose single
// multiplier forms the products and basis terms one per cycle; then the nine-cell ring
// rotates its coefficient entries past three channel multiply-accumulate units, each term
// passing low-half, high-half, sum and accumulate phases. The input is stalled while an
// evaluation is in progress; a finished result waits in the output register.
module sh_l2_irradiance_eval_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  operation,
	input  logic [shl2_pkg::IDX_W-1:0]            coef_index,
	input  logic signed [shl2_pkg::COEF_W-1:0]    coef_red,
	input  logic signed [shl2_pkg::COEF_W-1:0]    coef_green,
	input  logic signed [shl2_pkg::COEF_W-1:0]    coef_blue,
	input  logic signed [shl2_pkg::NRM_W-1:0]     normal_x,
	input  logic signed [shl2_pkg::NRM_W-1:0]     normal_y,
	input  logic signed [shl2_pkg::NRM_W-1:0]     normal_z,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [shl2_pkg::OUT_W-1:0]            irradiance_red,
	output logic [shl2_pkg::OUT_W-1:0]            irradiance_green,
	output logic [shl2_pkg::OUT_W-1:0]            irradiance_blue
);

	typedef enum logic [1:0] {ST_IDLE, ST_BASIS, ST_ACC, ST_DONE} state_t;

	localparam int N = shl2_pkg::N_TERMS;

	state_t                        state_q;
	shl2_pkg::mac_ph_t             ph_q;
	logic [shl2_pkg::IDX_W-1:0]    term_q;
	logic                          out_valid_q;
	logic [shl2_pkg::OUT_W-1:0]    red_q, green_q, blue_q;
	logic                          accept, start;
	shl2_pkg::basis_wr_t           bwr;
	logic                          bdone;
	shl2_pkg::mac_ctrl_t           mctl;
	shl2_pkg::cell_ctl_t           cctl [N];
	logic signed [shl2_pkg::COEF_W-1:0]  r_w [N];
	logic signed [shl2_pkg::COEF_W-1:0]  g_w [N];
	logic signed [shl2_pkg::COEF_W-1:0]  b_w [N];
	logic signed [shl2_pkg::BASIS_W-1:0] bs_w [N];
	logic signed [shl2_pkg::COEF_W-1:0]  acc_r, acc_g, acc_b;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign start    = accept && operation == shl2_pkg::OP_EVAL;

	assign mctl.clear = start;
	assign mctl.run   = (state_q == ST_ACC);
	assign mctl.ph    = ph_q;

	shl2_basis u_basis (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.nx     (normal_x),
		.ny     (normal_y),
		.nz     (normal_z),
		.wr     (bwr),
		.done   (bdone)
	);

	for (genvar i = 0; i < N; i++) begin : g_cell
		localparam int NX = (i + 1) % N;
		assign cctl[i].load  = accept && operation == shl2_pkg::OP_LOAD &&
			coef_index == shl2_pkg::IDX_W'(i);
		assign cctl[i].bwe   = bwr.we && bwr.idx == shl2_pkg::IDX_W'(i);
		assign cctl[i].shift = (state_q == ST_ACC) && ph_q == shl2_pkg::PH_ACC;
		shl2_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cctl[i]),
			.ld_r   (coef_red),
			.ld_g   (coef_green),
			.ld_b   (coef_blue),
			.bval   ($signed(bwr.val)),
			.nx_r   (r_w[NX]),
			.nx_g   (g_w[NX]),
			.nx_b   (b_w[NX]),
			.nx_bs  (bs_w[NX]),
			.cur_r  (r_w[i]),
			.cur_g  (g_w[i]),
			.cur_b  (b_w[i]),
			.cur_bs (bs_w[i])
		);
	end

	shl2_mac u_mac_r (.clk(clk), .ctrl(mctl), .coef(r_w[0]), .basis(bs_w[0]), .acc(acc_r));
	shl2_mac u_mac_g (.clk(clk), .ctrl(mctl), .coef(g_w[0]), .basis(bs_w[0]), .acc(acc_g));
	shl2_mac u_mac_b (.clk(clk), .ctrl(mctl), .coef(b_w[0]), .basis(bs_w[0]), .acc(acc_b));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ph_q        <= shl2_pkg::PH_LO;
			term_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_BASIS;
					end
				end
				ST_BASIS: begin
					if (bdone) begin
						state_q <= ST_ACC;
						ph_q    <= shl2_pkg::PH_LO;
						term_q  <= '0;
					end
				end
				ST_ACC: begin
					ph_q <= shl2_pkg::mac_ph_t'(ph_q + 2'd1);
					if (ph_q == shl2_pkg::PH_ACC) begin
						if (term_q == shl2_pkg::IDX_W'(N - 1)) begin
							state_q <= ST_DONE;
						end else begin
							term_q <= term_q + 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
			red_q   <= acc_r[63] ? '0 : acc_r[62:0];
			green_q <= acc_g[63] ? '0 : acc_g[62:0];
			blue_q  <= acc_b[63] ? '0 : acc_b[62:0];
		end
	end

	assign out_valid        = out_valid_q;
	assign irradiance_red   = red_q;
	assign irradiance_green = green_q;
	assign irradiance_blue  = blue_q;

endmodule

// ===== test/tb_sh_l2_irradiance_eval_unit.sv =====
// Self-checking testbench of the spherical harmonics irradiance evaluator.
module tb_sh_l2_irradiance_eval_unit;

	typedef struct {
		logic              op;
		logic [3:0]        idx;
		logic signed [63:0] cr, cg, cb;
		logic signed [33:0] nx, ny, nz;
		logic              chk;
		logic [62:0]       er, eg, eb;
	} stim_row_t;

	typedef struct {
		logic [62:0] r, g, b;
	} rgb_t;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [33:0] N_ONE   = 34'sh1_0000_0000;
	localparam logic signed [33:0] N_MONE  = -34'sh1_0000_0000;
	localparam logic signed [33:0] N_MAX   = 34'sh1_FFFF_FFFF;
	localparam logic signed [33:0] N_MIN   = 34'sh2_0000_0000;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic operation;
	logic [shl2_pkg::IDX_W-1:0] coef_index;
	logic signed [shl2_pkg::COEF_W-1:0] coef_red, coef_green, coef_blue;
	logic signed [shl2_pkg::NRM_W-1:0] normal_x, normal_y, normal_z;
	logic [shl2_pkg::OUT_W-1:0] irradiance_red, irradiance_green, irradiance_blue;

	logic signed [63:0] coef_table [shl2_pkg::N_TERMS][3];
	rgb_t irr_queue [$];
	stim_row_t rows [$];
	int mismatches, results_seen, beats_sent, evals_sent, loads_sent;
	bit hold_off, quiet;

	sh_l2_irradiance_eval_unit uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [127:0] p;
		p = (128'(a) * 128'(b)) >>> 32;
		if (p > 128'(S64_MAX)) return S64_MAX;
		if (p < 128'(S64_MIN)) return S64_MIN;
		return p[63:0];
	endfunction

	function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(S64_MAX)) return S64_MAX;
		if (s < 65'(S64_MIN)) return S64_MIN;
		return s[63:0];
	endfunction

	function automatic rgb_t irradiance_at(logic signed [33:0] nx, logic signed [33:0] ny,
			logic signed [33:0] nz);
		logic signed [63:0] x, y, z, bs [shl2_pkg::N_TERMS], acc [3];
		logic signed [63:0] k0, k1, k2, k3, k4, one;
		rgb_t res;
		x = nx; y = ny; z = nz;
		k0 = 64'sd1211559817; k1 = 64'sd2098485297; k2 = 64'sd4692484050;
		k3 = 64'sd1354578131; k4 = 64'sd2346242025; one = 64'sd4294967296;
		bs[0] = k0;
		bs[1] = qmul(-k1, y);
		bs[2] = qmul(k1, z);
		bs[3] = qmul(-k1, x);
		bs[4] = qmul(k2, qmul(x, y));
		bs[5] = qmul(-k2, qmul(y, z));
		bs[6] = qmul(k3, qmul(3 * one, qmul(z, z)) - one);
		bs[7] = qmul(-k2, qmul(x, z));
		bs[8] = qmul(k4, qmul(x, x) - qmul(y, y));
		for (int c = 0; c < 3; c++) acc[c] = 0;
		for (int i = 0; i < shl2_pkg::N_TERMS; i++)
			for (int c = 0; c < 3; c++)
				acc[c] = sat_add(acc[c], qmul(coef_table[i][c], bs[i]));
		res.r = acc[0] < 0 ? '0 : acc[0][62:0];
		res.g = acc[1] < 0 ? '0 : acc[1][62:0];
		res.b = acc[2] < 0 ? '0 : acc[2][62:0];
		return res;
	endfunction

	function automatic void add_row(logic op, logic [3:0] idx, logic signed [63:0] cr,
			logic signed [63:0] cg, logic signed [63:0] cb, logic signed [33:0] nx,
			logic signed [33:0] ny, logic signed [33:0] nz, logic chk = 1'b0,
			logic [62:0] er = '0, logic [62:0] eg = '0, logic [62:0] eb = '0);
		stim_row_t r;
		r.op = op; r.idx = idx; r.cr = cr; r.cg = cg; r.cb = cb;
		r.nx = nx; r.ny = ny; r.nz = nz; r.chk = chk; r.er = er; r.eg = eg; r.eb = eb;
		rows.push_back(r);
	endfunction

	function automatic logic signed [33:0] rand_normal();
		case ($urandom_range(0, 9))
			0: return N_MIN;
			1: return N_MAX;
			2: return N_ONE;
			3: return N_MONE;
			default: return 34'($signed($urandom_range(0, 32'h1FFF_FFFF)) - 33'sh1000_0000)
				<<< $urandom_range(0, 4);
		endcase
	endfunction

	function automatic logic signed [63:0] rand_coef();
		case ($urandom_range(0, 7))
			0: return S64_MAX;
			1: return S64_MIN;
			2: return {$urandom, $urandom};
			default: return 64'($signed({$urandom, $urandom}) >>> $urandom_range(16, 40));
		endcase
	endfunction

	task automatic send_beat(stim_row_t r);
		while (!quiet && $urandom_range(0, 99) < 25) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= r.op; coef_index <= r.idx;
		coef_red <= r.cr; coef_green <= r.cg; coef_blue <= r.cb;
		normal_x <= r.nx; normal_y <= r.ny; normal_z <= r.nz;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		beats_sent++;
		if (r.op == shl2_pkg::OP_EVAL) begin
			rgb_t e;
			e = irradiance_at(r.nx, r.ny, r.nz);
			if (r.chk && (e.r != r.er || e.g != r.eg || e.b != r.eb)) begin
				mismatches++;
				if (mismatches <= 10)
					$display("table row: exp %h %h %h got %h %h %h", r.er, r.eg, r.eb,
						e.r, e.g, e.b);
			end
			irr_queue.push_back(e);
			evals_sent++;
		end else begin
			loads_sent++;
			if (r.idx < shl2_pkg::N_TERMS) begin
				coef_table[r.idx][0] = r.cr;
				coef_table[r.idx][1] = r.cg;
				coef_table[r.idx][2] = r.cb;
			end
		end
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (irr_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat");
			end else begin
				rgb_t e;
				e = irr_queue.pop_front();
				if (e.r != irradiance_red || e.g != irradiance_green || e.b != irradiance_blue) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h %h %h got %h %h %h", e.r, e.g, e.b,
							irradiance_red, irradiance_green, irradiance_blue);
				end
			end
		end
	end

	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				hold_off = 1'b0;
			end
			out_stall <= !quiet && $urandom_range(0, 99) < 25;
		end
	end

	initial begin
		#20000000;
		$display("FAIL sh_l2_irradiance_eval_unit");
		$finish;
	end

	initial begin
		int n;
		stim_row_t r;
		in_valid = 0; operation = 0; coef_index = 0;
		coef_red = 0; coef_green = 0; coef_blue = 0;
		normal_x = 0; normal_y = 0; normal_z = 0;
		arst_n = 0;
		for (int i = 0; i < shl2_pkg::N_TERMS; i++)
			for (int c = 0; c < 3; c++) coef_table[i][c] = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// After reset every channel reads zero.
		add_row(shl2_pkg::OP_EVAL, 0, 0, 0, 0, N_ONE, N_MONE, 0, 1'b1, '0, '0, '0);
		// Constant term alone: one times K0.
		add_row(shl2_pkg::OP_LOAD, 0, 64'sh1_0000_0000, 64'sh1_0000_0000, 0, 0, 0, 0);
		add_row(shl2_pkg::OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 1'b1, 63'd1211559817, 63'd1211559817,
			'0);
		// Negative coefficient clamps to zero.
		add_row(shl2_pkg::OP_LOAD, 0, -64'sh1_0000_0000, S64_MAX, S64_MIN, 0, 0, 0);
		add_row(shl2_pkg::OP_EVAL, 0, 0, 0, 0, 0, 0, 0);
		add_row(shl2_pkg::OP_LOAD, 15, S64_MAX, S64_MAX, S64_MAX, 0, 0, 0);
		add_row(shl2_pkg::OP_LOAD, 9, S64_MIN, S64_MIN, S64_MIN, 0, 0, 0);
		for (int i = 1; i < shl2_pkg::N_TERMS; i++)
			add_row(shl2_pkg::OP_LOAD, i, S64_MAX, S64_MIN, 64'sh1_0000_0000, 0, 0, 0);
		add_row(shl2_pkg::OP_EVAL, 0, 0, 0, 0, N_MAX, N_MAX, N_MAX);
		add_row(shl2_pkg::OP_EVAL, 0, 0, 0, 0, N_MIN, N_MIN, N_MIN);
		add_row(shl2_pkg::OP_EVAL, 0, 0, 0, 0, N_ONE, N_MONE, N_ONE);
		add_row(shl2_pkg::OP_EVAL, 0, 0, 0, 0, N_MIN, N_MAX, 0);
		foreach (rows[i]) send_beat(rows[i]);

		n = 0;
		while (n < 600) begin
			if (n == 150) quiet = 1;
			if (n == 250) quiet = 0;
			if (n == 350) hold_off = 1;
			r.chk = 0;
			r.op = $urandom_range(0, 2) != 0;
			r.idx = $urandom_range(0, 19) == 0 ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
			r.cr = rand_coef(); r.cg = rand_coef(); r.cb = rand_coef();
			r.nx = rand_normal(); r.ny = rand_normal(); r.nz = rand_normal();
			send_beat(r);
			n++;
		end
		in_valid <= 1'b0;
		while (irr_queue.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Sent %0d beats (%0d loads, %0d evaluations), checked %0d results.",
			beats_sent, loads_sent, evals_sent, results_seen);
		if (mismatches == 0 && irr_queue.size() == 0)
			$display("PASS sh_l2_irradiance_eval_unit");
		else
			$display("FAIL sh_l2_irradiance_eval_unit");
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/shl2_pkg.sv
sv/shl2_cell.sv
sv/shl2_basis.sv
sv/shl2_mac.sv
sv/sh_l2_irradiance_eval_unit.sv
test/tb_sh_l2_irradiance_eval_unit.sv
